FILE: src/aes_cfb_pkg.sv
// Shared types, constants and byte functions for the AES-128 CFB cipher.
// No dependencies; used by aes_cfb_round and aes128_cfb_cipher.
package aes_cfb_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef logic [2:0] cfg_idx_t;

  localparam cfg_idx_t CFG_KEY_HIGH     = 3'd0;
  localparam cfg_idx_t CFG_KEY_LOW      = 3'd1;
  localparam cfg_idx_t CFG_IV_HIGH      = 3'd2;
  localparam cfg_idx_t CFG_IV_LOW       = 3'd3;
  localparam cfg_idx_t CFG_DECRYPT_MODE = 3'd4;

  localparam logic [3:0] NUM_ROUNDS = 4'd10;
  localparam logic [7:0] RCON_INIT  = 8'h01;
  localparam logic [7:0] GF_POLY    = 8'h1b;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] sbox(input logic [7:0] x);
    return SBOX[x];
  endfunction

  // multiply by x in GF(2^8)
  function automatic logic [7:0] xtime(input logic [7:0] x);
    return {x[6:0], 1'b0} ^ (x[7] ? GF_POLY : 8'h00);
  endfunction

endpackage

FILE: src/aes_cfb_round.sv
// One AES-128 encryption round with on-the-fly key schedule step.
// Combinational; depends on aes_cfb_pkg for the S-box and xtime.
module aes_cfb_round (
  input  logic [127:0] blk_in,
  input  logic [127:0] rk_in,
  input  logic [7:0]   rcon,
  input  logic         last,
  output logic [127:0] blk_out,
  output logic [127:0] rk_out
);

  logic [7:0]  s_b   [16];
  logic [7:0]  t_b   [16];
  logic [7:0]  m_b   [16];
  logic [7:0]  rk_b  [16];
  logic [31:0] sub_w;
  logic [31:0] w0, w1, w2, w3;
  logic [127:0] mixed;

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      s_b[i]  = blk_in[127 - 8*i -: 8];
      rk_b[i] = rk_in[127 - 8*i -: 8];
    end
    // sub bytes with shift rows
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t_b[4*c + r] = aes_cfb_pkg::sbox(s_b[4*((c + r) % 4) + r]);
      end
    end
    for (int c = 0; c < 4; c++) begin
      m_b[4*c]     = t_b[4*c] ^ (t_b[4*c] ^ t_b[4*c+1] ^ t_b[4*c+2] ^ t_b[4*c+3])
                     ^ aes_cfb_pkg::xtime(t_b[4*c] ^ t_b[4*c+1]);
      m_b[4*c + 1] = t_b[4*c+1] ^ (t_b[4*c] ^ t_b[4*c+1] ^ t_b[4*c+2] ^ t_b[4*c+3])
                     ^ aes_cfb_pkg::xtime(t_b[4*c+1] ^ t_b[4*c+2]);
      m_b[4*c + 2] = t_b[4*c+2] ^ (t_b[4*c] ^ t_b[4*c+1] ^ t_b[4*c+2] ^ t_b[4*c+3])
                     ^ aes_cfb_pkg::xtime(t_b[4*c+2] ^ t_b[4*c+3]);
      m_b[4*c + 3] = t_b[4*c+3] ^ (t_b[4*c] ^ t_b[4*c+1] ^ t_b[4*c+2] ^ t_b[4*c+3])
                     ^ aes_cfb_pkg::xtime(t_b[4*c+3] ^ t_b[4*c]);
    end
    for (int i = 0; i < 16; i++) begin
      mixed[127 - 8*i -: 8] = last ? t_b[i] : m_b[i];
    end
  end

  assign sub_w = {aes_cfb_pkg::sbox(rk_b[13]) ^ rcon, aes_cfb_pkg::sbox(rk_b[14]),
                  aes_cfb_pkg::sbox(rk_b[15]), aes_cfb_pkg::sbox(rk_b[12])};
  assign w0 = rk_in[127:96] ^ sub_w;
  assign w1 = rk_in[95:64]  ^ w0;
  assign w2 = rk_in[63:32]  ^ w1;
  assign w3 = rk_in[31:0]   ^ w2;
  assign rk_out  = {w0, w1, w2, w3};
  assign blk_out = mixed ^ rk_out;

endmodule

FILE: src/aes128_cfb_cipher.sv
// AES-128 full-block CFB cipher: top level with config registers and round sequencer.
// Depends on aes_cfb_pkg and aes_cfb_round.
// Sequence: the input transfer registers the key add into blk_r, then the ten rounds run, the
// last one written to res_r as out_valid rises; a new block is taken only after that finish.
// in_ready is low while a block is in the rounds; round ten holds while a result waits.
// Reset (rst_n, synchronous, active low): control, config and feedback registers cleared to zero; datapath not reset.
module aes128_cfb_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_data_high,
  input  logic [63:0] in_data_low,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_high,
  output logic [63:0] out_low
);

  aes_cfb_pkg::state_t state_r, state_nxt;

  logic [127:0] key_r, iv_r, fb_r;
  logic         decrypt_r;
  logic [127:0] blk_r, rk_r, data_r, res_r;
  logic [7:0]   rc_r;
  logic [3:0]   rnd_r;
  logic         out_valid_r, out_valid_nxt;

  logic         in_xfer, cfg_xfer, last, stall, finish, step;
  logic [127:0] round_blk, round_rk, result;

  aes_cfb_round u_round (
    .blk_in  (blk_r),
    .rk_in   (rk_r),
    .rcon    (rc_r),
    .last    (last),
    .blk_out (round_blk),
    .rk_out  (round_rk)
  );

  assign cfg_ready = 1'b1;
  assign cfg_xfer  = cfg_valid & cfg_ready;
  assign in_ready  = (state_r == aes_cfb_pkg::ST_IDLE);
  assign in_xfer   = in_valid & in_ready;
  assign last      = (rnd_r == aes_cfb_pkg::NUM_ROUNDS);
  assign stall     = out_valid_r & ~out_ready;
  assign finish    = (state_r == aes_cfb_pkg::ST_RUN) & last & ~stall;
  assign step      = (state_r == aes_cfb_pkg::ST_RUN) & ~last;
  assign result    = data_r ^ round_blk;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    case (state_r)
      aes_cfb_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = aes_cfb_pkg::ST_RUN;
      end
      aes_cfb_pkg::ST_RUN: begin
        if (finish) begin
          state_nxt     = aes_cfb_pkg::ST_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: state_nxt = aes_cfb_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= aes_cfb_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      key_r       <= '0;
      iv_r        <= '0;
      fb_r        <= '0;
      decrypt_r   <= 1'b0;
      rnd_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_xfer) begin
        case (cfg_index)
          aes_cfb_pkg::CFG_KEY_HIGH:     key_r[127:64] <= cfg_data;
          aes_cfb_pkg::CFG_KEY_LOW:      key_r[63:0]   <= cfg_data;
          aes_cfb_pkg::CFG_IV_HIGH:      iv_r[127:64]  <= cfg_data;
          aes_cfb_pkg::CFG_IV_LOW:       iv_r[63:0]    <= cfg_data;
          aes_cfb_pkg::CFG_DECRYPT_MODE: decrypt_r     <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_xfer) begin
        rnd_r <= 4'd1;
        if (in_restart) fb_r <= iv_r;
      end else if (step) begin
        rnd_r <= rnd_r + 4'd1;
      end
      if (finish) fb_r <= decrypt_r ? data_r : result;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      blk_r  <= (in_restart ? iv_r : fb_r) ^ key_r;
      rk_r   <= key_r;
      rc_r   <= aes_cfb_pkg::RCON_INIT;
      data_r <= {in_data_high, in_data_low};
    end else if (step) begin
      blk_r <= round_blk;
      rk_r  <= round_rk;
      rc_r  <= aes_cfb_pkg::xtime(rc_r);
    end
    if (finish) res_r <= result;
  end

  assign out_valid = out_valid_r;
  assign out_high  = res_r[127:64];
  assign out_low   = res_r[63:0];

endmodule

FILE: src/aes_cfb_chk.sv
// Port-level checker for aes128_cfb_cipher, bound to the top level.
// No package dependency; watches the data channels only.
module aes_cfb_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [63:0] out_high,
  input logic [63:0] out_low
);

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while block busy");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && !out_valid |-> ##11 out_valid)
    else $error("result not presented eleven cycles after input transfer");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_high) && $stable(out_low))
    else $error("stalled result changed");

endmodule

bind aes128_cfb_cipher aes_cfb_chk u_aes_cfb_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_high  (out_high),
  .out_low   (out_low)
);
